// ----- hw/rtl/qosc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qosc_pkg
// Shared types, register indexes, mode codes and the CORDIC arctangent table
// for the quadrature oscillator offset block.
// ----------------------------------------------------------------------------
package qosc_pkg;

  localparam int DT_W       = 16;
  localparam int RATE_W     = 24;
  localparam int AMP_W      = 16;
  localparam int MODE_W     = 2;
  localparam int OFS_W      = 17;
  localparam int TRIG_W     = 16;
  localparam int ANGLE_W    = 32;
  localparam int PROD_W     = RATE_W + DT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CORD_W     = 34;
  localparam int ITER_W     = 5;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'd652032874;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CIRCLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VERT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HORIZ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_ROT_GO,
    ST_ROT_WAIT,
    ST_SCL_GO,
    ST_SCL_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clr;
  } phase_ctrl_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/qosc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qosc_if
// Valid/ready channels: tick words in, offset words out.
// ----------------------------------------------------------------------------
interface qosc_in_if;
  logic                      valid;
  logic                      ready;
  logic [qosc_pkg::DT_W-1:0] elapsed_time;

  modport source(output valid, output elapsed_time, input ready);
  modport sink(input valid, input elapsed_time, output ready);
endinterface

interface qosc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qosc_pkg::OFS_W-1:0] offset_x;
  logic signed [qosc_pkg::OFS_W-1:0] offset_y;

  modport source(output valid, output offset_x, output offset_y, input ready);
  modport sink(input valid, input offset_x, input offset_y, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/qosc_phase.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qosc_phase
// Phase increment multiplier and wrapping phase accumulator.
// ----------------------------------------------------------------------------
module qosc_phase #(
  parameter int PHASE_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  qosc_pkg::phase_ctrl_t                ctrl,
  input  wire signed [qosc_pkg::RATE_W-1:0]    rate,
  input  wire        [qosc_pkg::DT_W-1:0]      dt,
  output logic       [qosc_pkg::ANGLE_W-1:0]   angle
);
  import qosc_pkg::*;

  localparam int SHL = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int SHR = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

  logic signed [PROD_W-1:0]         prod_r;
  logic        [PHASE_BITS-1:0]     phase_r;
  logic        [PHASE_BITS-1:0]     phase_nxt;
  logic signed [63:0]               prod_ext;
  logic signed [63:0]               inc_w;
  logic        [PHASE_BITS+31:0]    ang_cat;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= rate * $signed({1'b0, dt});
    end
  end

  always_comb begin
    prod_ext  = 64'(prod_r);
    inc_w     = (prod_ext <<< SHL) >>> SHR;
    phase_nxt = phase_r + inc_w[PHASE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      phase_r <= '0;
    end else if (ctrl.acc_en) begin
      phase_r <= phase_nxt;
    end
  end

  assign ang_cat = {phase_r, 32'd0};
  assign angle   = ang_cat[PHASE_BITS+31 -: ANGLE_W];

endmodule
`default_nettype wire

// ----- hw/rtl/qosc_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qosc_cordic
// Iterative rotation-mode CORDIC, one step per cycle, Q1.15 sine/cosine out.
// ----------------------------------------------------------------------------
module qosc_cordic #(
  parameter int SINE_ITERATIONS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire        [qosc_pkg::ANGLE_W-1:0]   angle,
  output logic                                 done,
  output logic signed [qosc_pkg::TRIG_W-1:0]   sin_q15,
  output logic signed [qosc_pkg::TRIG_W-1:0]   cos_q15
);
  import qosc_pkg::*;

  localparam int ITER = (SINE_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : SINE_ITERATIONS;
  localparam logic [ITER_W-1:0] LAST = ITER_W'(ITER - 1);

  logic signed [CORD_W-1:0] x_r, y_r, z_r;
  logic signed [CORD_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [CORD_W-1:0] xs, ys, at;
  logic        [ITER_W-1:0] cnt_r;
  logic                     run_r, cnv_r, done_r, flip_r;
  logic                     fold;
  logic        [ANGLE_W-1:0] ang_f;

  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] t;
    logic signed [CORD_W-1:0] r;
    logic signed [TRIG_W-1:0] q;
    t = v + 34'sd16384;
    r = t >>> 15;
    if (r > 34'sd32767) begin
      q = 16'sd32767;
    end else if (r < -34'sd32767) begin
      q = -16'sd32767;
    end else begin
      q = r[TRIG_W-1:0];
    end
    return q;
  endfunction

  // second and third quarter turns are rotated by half a turn
  assign fold  = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
  assign ang_f = fold ? {~angle[31], angle[30:0]} : angle;

  always_comb begin
    xs = y_r >>> cnt_r;
    ys = x_r >>> cnt_r;
    at = $signed({2'b00, atan_turn(cnt_r)});
    if (!z_r[CORD_W-1]) begin
      x_nxt = x_r - xs;
      y_nxt = y_r + ys;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + xs;
      y_nxt = y_r - ys;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_GAIN_Q30;
      y_r    <= '0;
      z_r    <= CORD_W'($signed(ang_f));
      flip_r <= fold;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
    if (cnv_r) begin
      sin_q15 <= to_q15(flip_r ? -y_r : y_r);
      cos_q15 <= to_q15(flip_r ? -x_r : x_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnv_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= cnv_r;
      cnv_r  <= run_r && (cnt_r == LAST);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ----- hw/rtl/qosc_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qosc_scale
// Amplitude scaling of sine then cosine through one shared multiplier.
// ----------------------------------------------------------------------------
module qosc_scale (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire signed [qosc_pkg::TRIG_W-1:0]    sin_q15,
  input  wire signed [qosc_pkg::TRIG_W-1:0]    cos_q15,
  input  wire        [qosc_pkg::AMP_W-1:0]     amp,
  output logic                                 done,
  output logic signed [qosc_pkg::OFS_W-1:0]    sin_ofs,
  output logic signed [qosc_pkg::OFS_W-1:0]    cos_ofs
);
  import qosc_pkg::*;

  localparam int MUL_W = TRIG_W + AMP_W + 1;

  logic signed [MUL_W-1:0]   prod_r;
  logic signed [TRIG_W-1:0]  opnd;
  logic signed [MUL_W:0]     rnd;
  logic        [1:0]         stp_r;
  logic                      done_r;

  assign opnd = (stp_r == 2'd0) ? sin_q15 : cos_q15;
  assign rnd  = (MUL_W + 1)'(prod_r) + 34'sd16384;

  always_ff @(posedge clk) begin
    if (start || stp_r == 2'd1) begin
      prod_r <= opnd * $signed({1'b0, amp});
    end
    if (stp_r == 2'd1) begin
      sin_ofs <= rnd[OFS_W+14:15];
    end
    if (stp_r == 2'd2) begin
      cos_ofs <= rnd[OFS_W+14:15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stp_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (stp_r == 2'd2);
      if (start) begin
        stp_r <= 2'd1;
      end else if (stp_r == 2'd1) begin
        stp_r <= 2'd2;
      end else begin
        stp_r <= 2'd0;
      end
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ----- hw/rtl/quadrature_oscillator_offset.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_oscillator_offset
// Quadrature oscillator: phase accumulator, CORDIC sine/cosine and amplitude
// scaling giving an x/y offset per tick word.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries tick words (elapsed_time); out_ch returns one offset word
//   (offset_x, offset_y) per tick. Both use valid/ready.
//   cfg_wr_en/cfg_index/cfg_data write mode (0), rate (1) and amplitude (2);
//   a mode write also clears the phase. Write only while the block is idle.
//   Each tick passes through the phase multiply and add, the CORDIC load,
//   ITER CORDIC rotation steps, one per cycle, where ITER is SINE_ITERATIONS
//   limited to 24 (16 by default), Q1.15 conversion, sine then cosine on the
//   shared scaling multiplier, the output load and sequencer hand-offs.
//   in_ch.ready is high only when the sequencer is idle. A finished offset
//   word sits in the output register; if out_ch is stalled the next tick is
//   still taken, and its result waits until the register is free.
//   Reset clears the configuration, the sequencer, the phase and output valid.
// ----------------------------------------------------------------------------
module quadrature_oscillator_offset #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_ITERATIONS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  qosc_in_if.sink                              in_ch,
  qosc_out_if.source                           out_ch,
  input  wire                                  cfg_wr_en,
  input  wire [qosc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [qosc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import qosc_pkg::*;

  state_t                    state_r, state_nxt;
  logic        [MODE_W-1:0]  mode_r;
  logic signed [RATE_W-1:0]  rate_r;
  logic        [AMP_W-1:0]   amp_r;

  phase_ctrl_t               pctl;
  logic                      rot_start, rot_done;
  logic                      scl_start, scl_done;
  logic                      ld_out;
  logic        [ANGLE_W-1:0] angle;
  logic signed [TRIG_W-1:0]  sin_q15, cos_q15;
  logic signed [OFS_W-1:0]   sin_ofs, cos_ofs;
  logic signed [OFS_W-1:0]   ox, oy;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [OFS_W-1:0]   ox_r, oy_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
      rate_r <= '0;
      amp_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE: mode_r <= cfg_data[MODE_W-1:0];
        CFG_RATE: rate_r <= $signed(cfg_data[RATE_W-1:0]);
        CFG_AMP:  amp_r  <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_ch.valid) state_nxt = ST_ADD;
      ST_ADD:      state_nxt = ST_ROT_GO;
      ST_ROT_GO:   state_nxt = ST_ROT_WAIT;
      ST_ROT_WAIT: if (rot_done) state_nxt = ST_SCL_GO;
      ST_SCL_GO:   state_nxt = ST_SCL_WAIT;
      ST_SCL_WAIT: if (scl_done) state_nxt = ST_OUT;
      ST_OUT:      if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    pctl        = '0;
    rot_start   = 1'b0;
    scl_start   = 1'b0;
    ld_out      = 1'b0;
    pctl.clr    = cfg_wr_en && (cfg_index == CFG_MODE);
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        pctl.mul_en = in_ch.valid;
      end
      ST_ADD:    pctl.acc_en = 1'b1;
      ST_ROT_GO: rot_start = 1'b1;
      ST_SCL_GO: scl_start = 1'b1;
      ST_OUT:    ld_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  qosc_phase #(
    .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (pctl),
    .rate  (rate_r),
    .dt    (in_ch.elapsed_time),
    .angle (angle)
  );

  qosc_cordic #(
    .SINE_ITERATIONS(SINE_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rot_start),
    .angle   (angle),
    .done    (rot_done),
    .sin_q15 (sin_q15),
    .cos_q15 (cos_q15)
  );

  qosc_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scl_start),
    .sin_q15 (sin_q15),
    .cos_q15 (cos_q15),
    .amp     (amp_r),
    .done    (scl_done),
    .sin_ofs (sin_ofs),
    .cos_ofs (cos_ofs)
  );

  always_comb begin
    ox = '0;
    oy = '0;
    case (mode_r)
      MODE_CIRCLE: begin
        ox = sin_ofs;
        oy = cos_ofs;
      end
      MODE_VERT:  oy = sin_ofs;
      MODE_HORIZ: ox = sin_ofs;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      ox_r <= ox;
      oy_r <= oy;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.offset_x = ox_r;
  assign out_ch.offset_y = oy_r;

endmodule
`default_nettype wire

// ----- tb/sv/quadrature_oscillator_offset_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_oscillator_offset_tb
// Self-checking bench for the quadrature oscillator offset block. A directed
// table covers the register extremes, every motion mode, quadrant boundaries
// and phase clearing. Randomised register sets and tick words follow under
// three idling regimes, with one long output stall. Each offset word is
// matched to its row's value or a bit-true phase, CORDIC and scale predictor.
// ----------------------------------------------------------------------------
module quadrature_oscillator_offset_tb;
  import qosc_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int PHASE_W       = 32;
  localparam int CORDIC_STEPS  = 16;
  localparam int DRAIN         = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEMS_PER_SET = 50;
  localparam int DIR_ROWS      = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // atan(2^-i), 2^-32 turn
  localparam longint TURN_ATAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
  } offset_t;

  typedef struct packed {
    bit                      wr;
    logic [MODE_W-1:0]       mode;
    logic [RATE_W-1:0]       rate;
    logic [AMP_W-1:0]        amp;
    logic [DT_W-1:0]         dt;
    bit                      known;
    logic signed [OFS_W-1:0] ex;
    logic signed [OFS_W-1:0] ey;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qosc_in_if  in_ch();
  qosc_out_if out_ch();

  quadrature_oscillator_offset #(
    .PHASE_BITS      (PHASE_W),
    .SINE_ITERATIONS (CORDIC_STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [MODE_W-1:0]       osc_mode;
  logic signed [RATE_W-1:0] osc_rate;
  logic [AMP_W-1:0]        osc_amp;
  logic [PHASE_W-1:0]      osc_phase;
  longint                  phase_step;
  offset_t                 offset_q[$];
  offset_t                 got_offset;
  int                      fail_cnt = 0;

  bit      tick_known;
  offset_t tick_val;
  int      tx_idle_pct  = 0;
  int      rx_stall_pct = 0;
  int      hold_asked   = 0;
  int      hold_served  = 0;
  int      hold_left    = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, MODE_NONE,   24'h000000, 16'h0000, 16'h0000, 1'b1, 17'sd0, 17'sd0},
    '{1'b0, MODE_NONE,   24'h000000, 16'h0000, 16'hFFFF, 1'b1, 17'sd0, 17'sd0},
    '{1'b1, MODE_CIRCLE, 24'h000000, 16'h0000, 16'h1234, 1'b1, 17'sd0, 17'sd0},
    '{1'b1, MODE_CIRCLE, 24'h000000, 16'h0100, 16'h0000, 1'b0, 17'sd0, 17'sd0},
    '{1'b1, MODE_CIRCLE, 24'h000000, 16'hFFFF, 16'h0000, 1'b0, 17'sd0, 17'sd0},
    '{1'b1, MODE_CIRCLE, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_CIRCLE, 24'h7FFFFF, 16'hFFFF, 16'h0001, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_CIRCLE, 24'h7FFFFF, 16'hFFFF, 16'h8000, 1'b0, 17'sd0, 17'sd0},
    '{1'b1, MODE_CIRCLE, 24'h800000, 16'hFFFF, 16'hFFFF, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_CIRCLE, 24'h800000, 16'hFFFF, 16'h0001, 1'b0, 17'sd0, 17'sd0},
    '{1'b1, MODE_VERT,   24'h010000, 16'h0100, 16'h4000, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_VERT,   24'h010000, 16'h0100, 16'h4000, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_VERT,   24'h010000, 16'h0100, 16'h4000, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_VERT,   24'h010000, 16'h0100, 16'h4000, 1'b0, 17'sd0, 17'sd0},
    '{1'b1, MODE_HORIZ,  24'h010000, 16'h7FFF, 16'h4000, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_HORIZ,  24'h010000, 16'h7FFF, 16'h4000, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_HORIZ,  24'h010000, 16'h7FFF, 16'h4000, 1'b0, 17'sd0, 17'sd0},
    '{1'b1, MODE_HORIZ,  24'h010000, 16'h7FFF, 16'h4000, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_HORIZ,  24'h010000, 16'h7FFF, 16'hC000, 1'b0, 17'sd0, 17'sd0},
    '{1'b1, MODE_NONE,   24'h123456, 16'hFFFF, 16'hABCD, 1'b1, 17'sd0, 17'sd0},
    '{1'b0, MODE_NONE,   24'h123456, 16'hFFFF, 16'hFFFF, 1'b1, 17'sd0, 17'sd0},
    '{1'b1, MODE_CIRCLE, 24'hFFFFFF, 16'h8000, 16'h2000, 1'b0, 17'sd0, 17'sd0},
    '{1'b0, MODE_CIRCLE, 24'hFFFFFF, 16'h8000, 16'h7FFF, 1'b0, 17'sd0, 17'sd0}
  };

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint to_trig(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  function automatic logic signed [OFS_W-1:0] amp_scale(input longint trig,
                                                        input logic [AMP_W-1:0] am);
    return OFS_W'((trig * longint'(am) + 16384) >>> 15);
  endfunction

  function automatic offset_t predict_offset(input logic [PHASE_W-1:0] ph,
                                             input logic [MODE_W-1:0] md,
                                             input logic [AMP_W-1:0] am);
    logic [31:0] ang;
    bit          flip;
    longint      x, y, z, xn, s, c;
    offset_t     o;
    ang  = ph;
    flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - TURN_ATAN[i];
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + TURN_ATAN[i];
      end
      x = xn;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = to_trig(y);
    c = to_trig(x);
    o = '0;
    case (md)
      MODE_CIRCLE: begin
        o.ox = amp_scale(s, am);
        o.oy = amp_scale(c, am);
      end
      MODE_VERT:  o.oy = amp_scale(s, am);
      MODE_HORIZ: o.ox = amp_scale(s, am);
      default: ;
    endcase
    return o;
  endfunction

  // predictor and scoreboard, all on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      osc_mode  = MODE_NONE;
      osc_rate  = '0;
      osc_amp   = '0;
      osc_phase = '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MODE: begin
            osc_mode  = cfg_data[MODE_W-1:0];
            osc_phase = '0;
          end
          CFG_RATE: osc_rate = cfg_data[RATE_W-1:0];
          CFG_AMP:  osc_amp  = cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        phase_step = longint'(osc_rate) * longint'(in_ch.elapsed_time);
        osc_phase  = osc_phase + phase_step[PHASE_W-1:0];
        if (tick_known) offset_q.push_back(tick_val);
        else offset_q.push_back(predict_offset(osc_phase, osc_mode, osc_amp));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (offset_q.size() == 0) begin
          $error("offset word with none expected: x %0d y %0d",
                 out_ch.offset_x, out_ch.offset_y);
          fail_cnt++;
        end else begin
          got_offset = offset_q.pop_front();
          if (out_ch.offset_x !== got_offset.ox) begin
            $error("offset_x: expected %0d, got %0d", got_offset.ox, out_ch.offset_x);
            fail_cnt++;
          end
          if (out_ch.offset_y !== got_offset.oy) begin
            $error("offset_y: expected %0d, got %0d", got_offset.oy, out_ch.offset_y);
            fail_cnt++;
          end
        end
      end
    end
  end

  // output back-pressure; a long hold-off is counted here
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_asked;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] md);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[MODE_W-1:0] = md;
    write_reg(CFG_MODE, d);
  endtask

  task automatic configure(input logic [MODE_W-1:0] md, input logic [RATE_W-1:0] rt,
                           input logic [AMP_W-1:0] am);
    logic [CFG_DATA_W-1:0] d;
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    write_mode(md);
    write_reg(CFG_RATE, rt);
    d = CFG_DATA_W'($urandom);
    d[AMP_W-1:0] = am;
    write_reg(CFG_AMP, d);
  endtask

  // drop valid, let every offset word out, then let the sequencer settle
  task automatic settle();
    in_ch.valid = 1'b0;
    while (offset_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tick(input logic [DT_W-1:0] dt, input bit known,
                           input offset_t val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid        = 1'b0;
      in_ch.elapsed_time = DT_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.elapsed_time = dt;
    tick_known         = known;
    tick_val           = val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    dir_row_t          row;
    offset_t           typed;
    logic [MODE_W-1:0] md;
    logic [RATE_W-1:0] rt;
    logic [AMP_W-1:0]  am;
    logic [DT_W-1:0]   dt;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = CFG_MODE;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.elapsed_time = '0;
    out_ch.ready       = 1'b0;
    tick_known         = 1'b0;
    tick_val           = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      if (row.wr) begin
        settle();
        configure(row.mode, row.rate, row.amp);
      end
      typed.ox = row.ex;
      typed.oy = row.ey;
      send_tick(row.dt, row.known, typed);
    end

    for (int g = 0; g < 3; g++) begin
      case (g)
        0: begin tx_idle_pct = 32; rx_stall_pct = 65; end
        1: begin tx_idle_pct = 65; rx_stall_pct = 32; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      for (int k = 0; k < 3; k++) begin
        settle();
        md = MODE_W'($urandom_range(3));
        case ($urandom_range(4))
          0: rt = 24'h7F_FFFF;
          1: rt = 24'h80_0000;
          2: rt = RATE_W'($urandom_range(8191)) - 24'd4096;
          default: rt = RATE_W'($urandom);
        endcase
        case ($urandom_range(9))
          0: am = 16'hFFFF;
          1: am = 16'h0000;
          default: am = AMP_W'($urandom);
        endcase
        configure(md, rt, am);
        if (g == 2 && k == 0) hold_asked++;
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
          if ($urandom_range(24) == 0) begin
            settle();
            write_mode(md);
          end
          case ($urandom_range(7))
            0: dt = 16'h0000;
            1: dt = 16'hFFFF;
            default: dt = DT_W'($urandom);
          endcase
          send_tick(dt, 1'b0, '0);
        end
      end
    end

    in_ch.valid = 1'b0;
    while (offset_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
